@@ rtl/kccl_pkg.sv @@
// ----------------------------------------------------------------------------
// kccl_pkg
// Shared constants, codes and helpers for the keepalive connection cache.
// ----------------------------------------------------------------------------
package kccl_pkg;

  localparam int CACHE_DEPTH  = 32;
  localparam int SLOT_BITS    = $clog2(CACHE_DEPTH);
  localparam int CNT_BITS     = $clog2(CACHE_DEPTH + 1);
  localparam int CONN_ID_BITS = 16;
  localparam int KEY_BITS     = 64;
  localparam int ENTRY_BITS   = KEY_BITS + CONN_ID_BITS;

  localparam logic [1:0] OP_GET   = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_CLOSED   = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  localparam logic [1:0] REG_CAPACITY      = 2'd0;
  localparam logic [1:0] REG_REQUEST_LIMIT = 2'd1;
  localparam logic [1:0] REG_MAX_AGE_MS    = 2'd2;

  localparam logic [5:0]  DEF_CAPACITY      = 6'd32;
  localparam logic [31:0] DEF_REQUEST_LIMIT = 32'd1000;
  localparam logic [31:0] DEF_MAX_AGE_MS    = 32'd3600000;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // Clamp the capacity register to 1..CACHE_DEPTH.
  function automatic cnt_t eff_capacity(input logic [5:0] cap);
    cnt_t res;
    if (cap == 6'd0) begin
      res = cnt_t'(1);
    end else if (32'(cap) > CACHE_DEPTH) begin
      res = cnt_t'(CACHE_DEPTH);
    end else begin
      res = cnt_t'(cap);
    end
    return res;
  endfunction

endpackage

@@ rtl/keepalive_connection_cache_lru.sv @@
// ----------------------------------------------------------------------------
// keepalive_connection_cache_lru
// LRU cache of idle connections keyed by peer address, with a LIFO free list.
//
// Channels: in_* carries one operation per beat (get, put or close); out_*
// returns exactly one result beat per operation. cfg_* writes capacity,
// request_limit and max_age_ms; a capacity write empties the cache.
// An operation is taken only while the sequencer is idle and no register
// write is pending. Operations run one at a time: get scans the recency
// list, one entry per cycle through the key RAM read port; close scans the
// recency list for the slot; a put into a free slot is written as it is
// taken; a put with eviction reads the oldest entry (S_EVRD, S_EVWR);
// reject and ignored go straight to S_OUT. Every result leaves via S_OUT,
// and the next operation is taken only once the sequencer is idle again.
// Reset (synchronous, rst_n low) empties the cache, fills the free list
// with slots 0..31 and restores the register defaults.
// A result waits in the output register while out_ready is low; the next
// input beat is accepted meanwhile, and its result waits until the output
// register drains.
// ----------------------------------------------------------------------------
module keepalive_connection_cache_lru (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_address_key,
  input  logic [15:0] in_conn_id,
  input  logic [4:0]  in_slot_index,
  input  logic        in_peer_failed,
  input  logic        in_conn_error,
  input  logic [31:0] in_request_count,
  input  logic [31:0] in_conn_age_ms,
  input  logic        in_keepalive_ok,
  input  logic        in_body_sent,
  input  logic        in_shutting_down,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_found_conn_id,
  output logic [4:0]  out_slot_used,
  output logic        out_evicted,
  output logic [15:0] out_evicted_conn_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import kccl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GET   = 3'd1;
  localparam logic [2:0] S_CLOSE = 3'd2;
  localparam logic [2:0] S_EVRD  = 3'd3;
  localparam logic [2:0] S_EVWR  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] req_limit_r, req_limit_nxt;
  logic [31:0] max_age_r, max_age_nxt;

  logic [CACHE_DEPTH-1:0] valid_r, valid_nxt;
  slot_t order_r [CACHE_DEPTH];
  slot_t order_nxt [CACHE_DEPTH];
  slot_t stack_r [CACHE_DEPTH];
  slot_t stack_nxt [CACHE_DEPTH];
  cnt_t  count_r, count_nxt;
  cnt_t  free_r, free_nxt;

  cnt_t  idx_r, idx_nxt;
  logic  cmp_valid_r, cmp_valid_nxt;
  slot_t cmp_pos_r, cmp_pos_nxt;
  slot_t cmp_slot_r, cmp_slot_nxt;
  slot_t ev_slot_r, ev_slot_nxt;

  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [CONN_ID_BITS-1:0] conn_r, conn_nxt;
  slot_t                   sidx_r, sidx_nxt;

  logic [2:0]  res_status_r, res_status_nxt;
  logic [15:0] res_found_r, res_found_nxt;
  slot_t       res_slot_r, res_slot_nxt;
  logic        res_ev_r, res_ev_nxt;
  logic [15:0] res_ev_conn_r, res_ev_conn_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [15:0] out_found_r, out_found_nxt;
  slot_t       out_slot_r, out_slot_nxt;
  logic        out_ev_r, out_ev_nxt;
  logic [15:0] out_ev_conn_r, out_ev_conn_nxt;

  logic                     ram_we;
  slot_t                    ram_waddr;
  logic [ENTRY_BITS-1:0]    ram_wdata;
  slot_t                    ram_raddr;
  logic [ENTRY_BITS-1:0]    ram_rdata;
  logic [KEY_BITS-1:0]      rd_key;
  logic [CONN_ID_BITS-1:0]  rd_conn;

  logic  rel_en, ins_en, pop_en, ev_en, rebuild;
  slot_t rel_pos, rel_slot, ins_slot;
  cnt_t  rebuild_cap;
  logic  in_fire, cfg_fire, reject;
  slot_t last_pos, top_pos;

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign rd_key   = ram_rdata[ENTRY_BITS-1:CONN_ID_BITS];
  assign rd_conn  = ram_rdata[CONN_ID_BITS-1:0];
  assign last_pos = slot_t'(count_r - cnt_t'(1));
  assign top_pos  = slot_t'(free_r - cnt_t'(1));

  assign reject = in_peer_failed || in_conn_error || (in_request_count >= req_limit_r) ||
                  (in_conn_age_ms > max_age_r) || !in_keepalive_ok || !in_body_sent ||
                  in_shutting_down;

  kccl_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(CACHE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = (state_r == S_GET) ? order_r[slot_t'(idx_r)] : order_r[last_pos];

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    req_limit_nxt   = req_limit_r;
    max_age_nxt     = max_age_r;
    idx_nxt         = idx_r;
    cmp_valid_nxt   = cmp_valid_r;
    cmp_pos_nxt     = cmp_pos_r;
    cmp_slot_nxt    = cmp_slot_r;
    ev_slot_nxt     = ev_slot_r;
    key_nxt         = key_r;
    conn_nxt        = conn_r;
    sidx_nxt        = sidx_r;
    res_status_nxt  = res_status_r;
    res_found_nxt   = res_found_r;
    res_slot_nxt    = res_slot_r;
    res_ev_nxt      = res_ev_r;
    res_ev_conn_nxt = res_ev_conn_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_slot_nxt    = out_slot_r;
    out_ev_nxt      = out_ev_r;
    out_ev_conn_nxt = out_ev_conn_r;
    rel_en          = 1'b0;
    rel_pos         = '0;
    rel_slot        = '0;
    ins_en          = 1'b0;
    ins_slot        = '0;
    pop_en          = 1'b0;
    ev_en           = 1'b0;
    rebuild         = 1'b0;
    rebuild_cap     = eff_capacity(cfg_data[5:0]);
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = {in_address_key, in_conn_id[CONN_ID_BITS-1:0]};

    unique case (state_r)
      S_IDLE: begin
        if (cfg_fire) begin
          unique case (cfg_index)
            REG_CAPACITY:      rebuild = 1'b1;
            REG_REQUEST_LIMIT: req_limit_nxt = cfg_data;
            REG_MAX_AGE_MS:    max_age_nxt = cfg_data;
            default: ;
          endcase
        end
        if (in_fire) begin
          key_nxt         = in_address_key;
          conn_nxt        = in_conn_id[CONN_ID_BITS-1:0];
          sidx_nxt        = in_slot_index;
          res_found_nxt   = '0;
          res_slot_nxt    = '0;
          res_ev_nxt      = 1'b0;
          res_ev_conn_nxt = '0;
          res_status_nxt  = ST_IGNORED;
          idx_nxt         = '0;
          cmp_valid_nxt   = 1'b0;
          unique case (in_operation)
            OP_GET: state_nxt = S_GET;
            OP_PUT: begin
              if (reject) begin
                res_status_nxt = ST_REJECTED;
                state_nxt      = S_OUT;
              end else if (free_r == '0) begin
                state_nxt = S_EVRD;
              end else begin
                pop_en         = 1'b1;
                ins_en         = 1'b1;
                ins_slot       = stack_r[top_pos];
                ram_we         = 1'b1;
                ram_waddr      = stack_r[top_pos];
                res_status_nxt = ST_STORED;
                res_slot_nxt   = stack_r[top_pos];
                state_nxt      = S_OUT;
              end
            end
            OP_CLOSE: state_nxt = valid_r[in_slot_index] ? S_CLOSE : S_OUT;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_GET: begin
        if (cmp_valid_r && (rd_key == key_r)) begin
          rel_en         = 1'b1;
          rel_pos        = cmp_pos_r;
          rel_slot       = cmp_slot_r;
          res_status_nxt = ST_HIT;
          res_found_nxt  = 16'(rd_conn);
          res_slot_nxt   = cmp_slot_r;
          state_nxt      = S_OUT;
        end else if (idx_r == count_r) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_OUT;
        end else begin
          cmp_valid_nxt = 1'b1;
          cmp_pos_nxt   = slot_t'(idx_r);
          cmp_slot_nxt  = order_r[slot_t'(idx_r)];
          idx_nxt       = idx_r + cnt_t'(1);
        end
      end
      S_CLOSE: begin
        if (idx_r == count_r) begin
          res_status_nxt = ST_CLOSED;
          res_slot_nxt   = sidx_r;
          state_nxt      = S_OUT;
        end else if (order_r[slot_t'(idx_r)] == sidx_r) begin
          rel_en         = 1'b1;
          rel_pos        = slot_t'(idx_r);
          rel_slot       = sidx_r;
          res_status_nxt = ST_CLOSED;
          res_slot_nxt   = sidx_r;
          state_nxt      = S_OUT;
        end else begin
          idx_nxt = idx_r + cnt_t'(1);
        end
      end
      S_EVRD: begin
        ev_slot_nxt = order_r[last_pos];
        state_nxt   = S_EVWR;
      end
      S_EVWR: begin
        ev_en           = 1'b1;
        ins_en          = 1'b1;
        ins_slot        = ev_slot_r;
        ram_we          = 1'b1;
        ram_waddr       = ev_slot_r;
        ram_wdata       = {key_r, conn_r};
        res_status_nxt  = ST_STORED;
        res_slot_nxt    = ev_slot_r;
        res_ev_nxt      = 1'b1;
        res_ev_conn_nxt = 16'(rd_conn);
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_found_nxt   = res_found_r;
          out_slot_nxt    = res_slot_r;
          out_ev_nxt      = res_ev_r;
          out_ev_conn_nxt = res_ev_conn_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Recency list, free stack and valid bits
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    free_nxt  = free_r;
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      order_nxt[j] = order_r[j];
      stack_nxt[j] = stack_r[j];
    end
    if (rel_en) begin
      for (int j = 0; j < CACHE_DEPTH - 1; j++) begin
        if (slot_t'(j) >= rel_pos) begin
          order_nxt[j] = order_r[j+1];
        end
      end
      count_nxt          = count_r - cnt_t'(1);
      valid_nxt[rel_slot] = 1'b0;
      if (32'(free_r) < CACHE_DEPTH) begin
        stack_nxt[slot_t'(free_r)] = rel_slot;
        free_nxt                   = free_r + cnt_t'(1);
      end
    end
    if (pop_en) begin
      free_nxt = free_r - cnt_t'(1);
    end
    if (ins_en) begin
      for (int j = 1; j < CACHE_DEPTH; j++) begin
        order_nxt[j] = order_r[j-1];
      end
      order_nxt[0]        = ins_slot;
      valid_nxt[ins_slot] = 1'b1;
      if (!ev_en) begin
        count_nxt = count_r + cnt_t'(1);
      end
    end
    if (rebuild) begin
      valid_nxt = '0;
      count_nxt = '0;
      free_nxt  = rebuild_cap;
      for (int j = 0; j < CACHE_DEPTH; j++) begin
        stack_nxt[j] = slot_t'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_limit_r <= DEF_REQUEST_LIMIT;
      max_age_r   <= DEF_MAX_AGE_MS;
      valid_r     <= '0;
      count_r     <= '0;
      free_r      <= eff_capacity(DEF_CAPACITY);
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < CACHE_DEPTH; j++) begin
        stack_r[j] <= slot_t'(j);
      end
    end else begin
      state_r     <= state_nxt;
      req_limit_r <= req_limit_nxt;
      max_age_r   <= max_age_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int j = 0; j < CACHE_DEPTH; j++) begin
        stack_r[j] <= stack_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      order_r[j] <= order_nxt[j];
    end
    idx_r         <= idx_nxt;
    cmp_pos_r     <= cmp_pos_nxt;
    cmp_slot_r    <= cmp_slot_nxt;
    ev_slot_r     <= ev_slot_nxt;
    key_r         <= key_nxt;
    conn_r        <= conn_nxt;
    sidx_r        <= sidx_nxt;
    res_status_r  <= res_status_nxt;
    res_found_r   <= res_found_nxt;
    res_slot_r    <= res_slot_nxt;
    res_ev_r      <= res_ev_nxt;
    res_ev_conn_r <= res_ev_conn_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_slot_r    <= out_slot_nxt;
    out_ev_r      <= out_ev_nxt;
    out_ev_conn_r <= out_ev_conn_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found_conn_id   = out_found_r;
  assign out_slot_used       = out_slot_r;
  assign out_evicted         = out_ev_r;
  assign out_evicted_conn_id = out_ev_conn_r;

endmodule

@@ rtl/kccl_ram.sv @@
// ----------------------------------------------------------------------------
// kccl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kccl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
